// ----- design/aavr_pkg.sv -----
package aavr_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 24;

   // Fixed widths of the datapath
   localparam int WORD_W  = 32;
   localparam int ROT_W   = 34;   // CORDIC x, y, z
   localparam int ANG_W   = 24;   // folded angle, Q8.16 degrees

   localparam logic signed [ROT_W-1:0] CORDIC_X0 = 34'sd652032874;   // gain-compensated 1.0
   localparam logic signed [31:0]      ONE_Q30   = 32'sd1073741824;
   localparam logic signed [31:0]      WORD_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]      WORD_MIN  = 32'sh8000_0000;

   // Angle reduction: 360 deg in Q16.16 is 45 * 2^19
   localparam logic [13:0] TURN_BIAS   = 14'd4140;   // 92 * 45, lifts the turn index above zero
   localparam logic [10:0] RECIP_45    = 11'd1457;   // ceil(2^16 / 45)
   localparam logic signed [25:0] DEG360 = 26'sd23592960;
   localparam logic signed [25:0] DEG180 = 26'sd11796480;
   localparam logic signed [25:0] DEG90  = 26'sd5898240;
   localparam logic signed [51:0] DEG_TO_RAD = 52'sd74961321;   // pi/180 in Q0.32

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type vec_x;
      word_type vec_y;
      word_type vec_z;
      word_type axis_x;
      word_type axis_y;
      word_type axis_z;
      word_type angle_deg;
   } req_type;

   typedef struct packed {
      word_type rot_x;
      word_type rot_y;
      word_type rot_z;
      logic     saturated;
   } rsp_type;

   // Operands that ride along the CORDIC chain
   typedef struct packed {
      word_type vec_x;
      word_type vec_y;
      word_type vec_z;
      word_type axis_x;
      word_type axis_y;
      word_type axis_z;
      logic     neg;
   } side_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
   } cordic_type;

   // atan(2^-i) in Q2.30
   function automatic logic signed [ROT_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [ROT_W-1:0] v;
      case (i)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/axis_angle_vector_rotate_top.sv -----
// Rotates a Q16.16 vector about a Q2.30 axis (used as given, not normalized) by an angle in
// Q16.16 degrees. The receiver cannot stall: every transfer taken on start comes back as
// exactly one rsp_valid strobe, in order. The block takes one transfer per cycle; busy is
// high only during reset. Each result passes through the angle front end (4 registers), the
// chain of CORDIC cells (one register per iteration) and the Rodrigues matrix back end
// (6 registers, stages E to J).
module axis_angle_vector_rotate_top import aavr_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int LATENCY = CORDIC_STAGES + 10;

   logic [3:0] front_valid_ff;
   logic       accept;

   // stage A: split the angle into turn index and fraction
   logic [13:0] turn_a_ff, turn_a_in;
   logic [18:0] frac_a_ff;
   side_type    side_a_ff;
   // stage B: reciprocal product for index mod 45
   logic [24:0] quot_b_ff, quot_b_in;
   logic [13:0] turn_b_ff;
   logic [18:0] frac_b_ff;
   side_type    side_b_ff;
   // stage C: folded angle in [-90, 90] degrees
   logic [8:0]  quot_in;
   logic signed [14:0] rem_in;
   logic [5:0]  rem6_in;
   logic signed [25:0] r_in;
   logic        neg_in;
   side_type    side_c_in;
   logic signed [ANG_W-1:0] r_c_ff;
   side_type    side_c_ff;
   // stage D: radians
   logic signed [51:0] theta_prod;
   cordic_type  rot_d_ff;
   side_type    side_d_ff;

   logic       chain_valid [CORDIC_STAGES+1];
   cordic_type chain_rot   [CORDIC_STAGES+1];
   side_type   chain_side  [CORDIC_STAGES+1];

   // never hold off a transfer except in reset
   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else begin
         front_valid_ff <= {front_valid_ff[2:0], accept};
      end
   end

   // floor(angle / 2^19) biased into a positive range; mod 45 is unchanged
   assign turn_a_in = 14'({req_data.angle_deg[31], req_data.angle_deg[31:19]}) + TURN_BIAS;

   always_ff @(posedge clock) begin
      turn_a_ff        <= turn_a_in;
      frac_a_ff        <= req_data.angle_deg[18:0];
      side_a_ff.vec_x  <= req_data.vec_x;
      side_a_ff.vec_y  <= req_data.vec_y;
      side_a_ff.vec_z  <= req_data.vec_z;
      side_a_ff.axis_x <= req_data.axis_x;
      side_a_ff.axis_y <= req_data.axis_y;
      side_a_ff.axis_z <= req_data.axis_z;
      side_a_ff.neg    <= 1'b0;
   end

   assign quot_b_in = 25'(turn_a_ff) * 25'(RECIP_45);

   always_ff @(posedge clock) begin
      quot_b_ff <= quot_b_in;
      turn_b_ff <= turn_a_ff;
      frac_b_ff <= frac_a_ff;
      side_b_ff <= side_a_ff;
   end

   always_comb begin
      // the quotient estimate can run one high: correct with a single add
      quot_in = quot_b_ff[24:16];
      rem_in  = $signed(15'(turn_b_ff)) - $signed(15'(quot_in) * 15'd45);
      if (rem_in[14]) begin
         rem_in = rem_in + 15'sd45;
      end
      rem6_in = rem_in[5:0];
      r_in    = $signed({1'b0, rem6_in, frac_b_ff});
      neg_in  = 1'b0;
      if (r_in > DEG180) begin
         r_in = r_in - DEG360;
      end
      // fold into [-90, 90]; flip cos and sin at the end
      if (r_in > DEG90) begin
         r_in   = r_in - DEG180;
         neg_in = 1'b1;
      end else if (r_in < -DEG90) begin
         r_in   = r_in + DEG180;
         neg_in = 1'b1;
      end
      side_c_in     = side_b_ff;
      side_c_in.neg = neg_in;
   end

   always_ff @(posedge clock) begin
      r_c_ff    <= ANG_W'(r_in);
      side_c_ff <= side_c_in;
   end

   assign theta_prod = 52'(r_c_ff) * DEG_TO_RAD;

   always_ff @(posedge clock) begin
      rot_d_ff.x <= CORDIC_X0;
      rot_d_ff.y <= '0;
      rot_d_ff.z <= ROT_W'(theta_prod >>> 18);
      side_d_ff  <= side_c_ff;
   end

   assign chain_valid[0] = front_valid_ff[3];
   assign chain_rot[0]   = rot_d_ff;
   assign chain_side[0]  = side_d_ff;

   // one cell per CORDIC iteration, each hands its result to the next every cycle
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      aavr_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_rot    (chain_rot[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_rot   (chain_rot[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   aavr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_rot    (chain_rot[CORDIC_STAGES]),
      .in_side   (chain_side[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   // every accepted transfer returns after a fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result strobe missing after fixed latency");

   // the flag is set only when a component sits at a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.rot_x == WORD_MAX || rsp_data.rot_x == WORD_MIN ||
         rsp_data.rot_y == WORD_MAX || rsp_data.rot_y == WORD_MIN ||
         rsp_data.rot_z == WORD_MAX || rsp_data.rot_z == WORD_MIN)
      else $error("saturated flag without a clipped component");

   // no strobe without a transfer taken in the right cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset, LATENCY) |-> $past(accept, LATENCY))
      else $error("result strobe without a matching transfer");

endmodule

// ----- design/aavr_cordic_cell.sv -----
module aavr_cordic_cell import aavr_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_rot,
   input  side_type   in_side,
   output logic       out_valid,
   output cordic_type out_rot,
   output side_type   out_side
);

   localparam logic signed [ROT_W-1:0] ANGLE = atan_q30(5'(STAGE));

   logic       valid_ff;
   cordic_type rot_ff, rot_in;
   side_type   side_ff;

   always_comb begin
      // rotate toward z = 0, one micro-rotation per cell
      if (!in_rot.z[ROT_W-1]) begin
         rot_in.x = in_rot.x - (in_rot.y >>> STAGE);
         rot_in.y = in_rot.y + (in_rot.x >>> STAGE);
         rot_in.z = in_rot.z - ANGLE;
      end else begin
         rot_in.x = in_rot.x + (in_rot.y >>> STAGE);
         rot_in.y = in_rot.y - (in_rot.x >>> STAGE);
         rot_in.z = in_rot.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff  <= rot_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_side  = side_ff;

endmodule

// ----- design/aavr_matrix.sv -----
module aavr_matrix import aavr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_rot,
   input  side_type   in_side,
   output logic       out_valid,
   output rsp_type    out_rsp
);

   logic [5:0] valid_ff;

   // stage E: sign fold and clamp
   logic signed [ROT_W-1:0] cx_in, sy_in;
   logic signed [31:0] c_e_ff, s_e_ff, c_e_in, s_e_in;
   word_type v_e_ff [3];
   word_type a_e_ff [3];

   // stage F: (1 - c) * axis and axis * s
   logic signed [32:0] t_in;
   logic signed [64:0] u_prod [3];
   logic signed [63:0] s_prod [3];
   logic signed [33:0] u_f_ff [3];
   logic signed [33:0] as_f_ff [3];
   logic signed [31:0] c_f_ff;
   word_type v_f_ff [3];
   word_type a_f_ff [3];

   // stage G: outer-product terms
   logic signed [65:0] uu_prod [6];
   logic signed [35:0] uu_g_ff [6];
   logic signed [33:0] as_g_ff [3];
   logic signed [31:0] c_g_ff;
   word_type v_g_ff [3];

   // stage H: matrix entries, row-major
   logic signed [36:0] m_h_ff [9];
   logic signed [36:0] m_in [9];
   word_type v_h_ff [3];

   // stage I: matrix times vector terms
   logic signed [68:0] mv_prod [9];
   logic signed [38:0] mv_i_ff [9];

   // stage J: row sums and saturation
   logic signed [40:0] sum_in [3];
   word_type rot_in [3];
   logic [2:0] clip_in;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_comb begin
      cx_in = in_side.neg ? -in_rot.x : in_rot.x;
      sy_in = in_side.neg ? -in_rot.y : in_rot.y;
      if (cx_in > 34'(ONE_Q30))       c_e_in = ONE_Q30;
      else if (cx_in < -34'(ONE_Q30)) c_e_in = -ONE_Q30;
      else                            c_e_in = 32'(cx_in);
      if (sy_in > 34'(ONE_Q30))       s_e_in = ONE_Q30;
      else if (sy_in < -34'(ONE_Q30)) s_e_in = -ONE_Q30;
      else                            s_e_in = 32'(sy_in);
   end

   always_ff @(posedge clock) begin
      c_e_ff  <= c_e_in;
      s_e_ff  <= s_e_in;
      v_e_ff  <= '{in_side.vec_x, in_side.vec_y, in_side.vec_z};
      a_e_ff  <= '{in_side.axis_x, in_side.axis_y, in_side.axis_z};
   end

   always_comb begin
      t_in = 33'(ONE_Q30) - 33'(c_e_ff);
      for (int k = 0; k < 3; k++) begin
         u_prod[k] = 65'(t_in) * 65'(a_e_ff[k]);
         s_prod[k] = 64'(a_e_ff[k]) * 64'(s_e_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         u_f_ff[k]  <= 34'(u_prod[k] >>> 30);
         as_f_ff[k] <= 34'(s_prod[k] >>> 30);
      end
      c_f_ff <= c_e_ff;
      v_f_ff <= v_e_ff;
      a_f_ff <= a_e_ff;
   end

   // ux*ax, ux*ay, ux*az, uy*ay, uy*az, uz*az
   always_comb begin
      uu_prod[0] = 66'(u_f_ff[0]) * 66'(a_f_ff[0]);
      uu_prod[1] = 66'(u_f_ff[0]) * 66'(a_f_ff[1]);
      uu_prod[2] = 66'(u_f_ff[0]) * 66'(a_f_ff[2]);
      uu_prod[3] = 66'(u_f_ff[1]) * 66'(a_f_ff[1]);
      uu_prod[4] = 66'(u_f_ff[1]) * 66'(a_f_ff[2]);
      uu_prod[5] = 66'(u_f_ff[2]) * 66'(a_f_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         uu_g_ff[k] <= 36'(uu_prod[k] >>> 30);
      end
      as_g_ff <= as_f_ff;
      c_g_ff  <= c_f_ff;
      v_g_ff  <= v_f_ff;
   end

   // as_g_ff holds ax*s, ay*s, az*s
   always_comb begin
      m_in[0] = 37'(c_g_ff) + 37'(uu_g_ff[0]);
      m_in[1] = 37'(uu_g_ff[1]) - 37'(as_g_ff[2]);
      m_in[2] = 37'(uu_g_ff[2]) + 37'(as_g_ff[1]);
      m_in[3] = 37'(uu_g_ff[1]) + 37'(as_g_ff[2]);
      m_in[4] = 37'(c_g_ff) + 37'(uu_g_ff[3]);
      m_in[5] = 37'(uu_g_ff[4]) - 37'(as_g_ff[0]);
      m_in[6] = 37'(uu_g_ff[2]) - 37'(as_g_ff[1]);
      m_in[7] = 37'(uu_g_ff[4]) + 37'(as_g_ff[0]);
      m_in[8] = 37'(c_g_ff) + 37'(uu_g_ff[5]);
   end

   always_ff @(posedge clock) begin
      m_h_ff <= m_in;
      v_h_ff <= v_g_ff;
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         mv_prod[k] = 69'(m_h_ff[k]) * 69'(v_h_ff[k % 3]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         mv_i_ff[k] <= 39'(mv_prod[k] >>> 30);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 41'(mv_i_ff[3*r]) + 41'(mv_i_ff[3*r+1]) + 41'(mv_i_ff[3*r+2]);
         if (sum_in[r] > 41'(WORD_MAX)) begin
            rot_in[r]  = WORD_MAX;
            clip_in[r] = 1'b1;
         end else if (sum_in[r] < 41'(WORD_MIN)) begin
            rot_in[r]  = WORD_MIN;
            clip_in[r] = 1'b1;
         end else begin
            rot_in[r]  = 32'(sum_in[r]);
            clip_in[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.rot_x     <= rot_in[0];
      rsp_ff.rot_y     <= rot_in[1];
      rsp_ff.rot_z     <= rot_in[2];
      rsp_ff.saturated <= |clip_in;
   end

   assign out_valid = valid_ff[5];
   assign out_rsp   = rsp_ff;

endmodule

// ----- dv/axis_angle_vector_rotate_top_tb.sv -----
module axis_angle_vector_rotate_top_tb;
   import aavr_pkg::*;

   localparam int STAGES  = CORDIC_STAGES_DEFAULT;
   localparam int LATENCY = STAGES + 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   axis_angle_vector_rotate_top #(.CORDIC_STAGES(STAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Vectors waiting to be sent, and rotations expected back in order
   req_type pending_vectors[$];
   rsp_type expected_rotations[$];
   int      error_count = 0;
   bit      stimulus_done = 0;
   bit      hold_for_drain = 0;   // pause sending until every rotation has returned
   int      burst_left = 0;
   int      gap_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor(a*b / 2^30) exactly, split so the product fits in 64 bits
   function automatic longint mul_q30(longint a, longint b);
      longint hi;
      longint lo;
      hi = a >>> 15;
      lo = a & 64'h7FFF;
      return (hi * b + ((lo * b) >>> 15)) >>> 15;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic longint atan_entry(int i);
      longint atan_list[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
         31, 15, 8, 4, 2, 1, 0};
      return atan_list[i];
   endfunction

   // Rodrigues rotation of one vector, saturated per component
   function automatic rsp_type rotate_vector(req_type rq);
      longint v[3];
      longint ax, ay, az, r, x, y, z, dx, dy, c, s, t, ux, uy, uz, sum;
      longint m[3][3];
      bit     neg;
      rsp_type rs;
      v[0] = rq.vec_x;
      v[1] = rq.vec_y;
      v[2] = rq.vec_z;
      ax = rq.axis_x;
      ay = rq.axis_y;
      az = rq.axis_z;
      neg = 0;
      r = longint'(rq.angle_deg) % 23592960;
      if (r < 0) r += 23592960;
      if (r > 11796480) r -= 23592960;
      if (r > 5898240) begin
         r -= 11796480;
         neg = 1;
      end else if (r < -5898240) begin
         r += 11796480;
         neg = 1;
      end
      z = (r * 74961321) >>> 18;
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> (i % 32);
         dy = x >>> (i % 32);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_entry(i % 32);
         end else begin
            x += dx; y -= dy; z += atan_entry(i % 32);
         end
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
      t = 64'sd1073741824 - c;
      ux = mul_q30(t, ax);
      uy = mul_q30(t, ay);
      uz = mul_q30(t, az);
      m[0][0] = c + mul_q30(ux, ax);
      m[0][1] = mul_q30(ux, ay) - mul_q30(az, s);
      m[0][2] = mul_q30(ux, az) + mul_q30(ay, s);
      m[1][0] = mul_q30(ux, ay) + mul_q30(az, s);
      m[1][1] = c + mul_q30(uy, ay);
      m[1][2] = mul_q30(uy, az) - mul_q30(ax, s);
      m[2][0] = mul_q30(ux, az) - mul_q30(ay, s);
      m[2][1] = mul_q30(uy, az) + mul_q30(ax, s);
      m[2][2] = c + mul_q30(uz, az);
      rs.saturated = 1'b0;
      for (int k = 0; k < 3; k++) begin
         sum = mul_q30(m[k][0], v[0]) + mul_q30(m[k][1], v[1]) + mul_q30(m[k][2], v[2]);
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            rs.saturated = 1'b1;
         end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            rs.saturated = 1'b1;
         end
         case (k)
            0: rs.rot_x = word_type'(sum);
            1: rs.rot_y = word_type'(sum);
            default: rs.rot_z = word_type'(sum);
         endcase
      end
      return rs;
   endfunction

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   // Unit axes built from a few directions in half the draws; the other half are random non-unit axes
   function automatic req_type random_vector();
      req_type rq;
      int sel;
      rq.vec_x = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($signed($urandom) >>> 8);
      rq.vec_y = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($signed($urandom) >>> 8);
      rq.vec_z = $urandom_range(0, 3) == 0 ? rand_word() : word_type'($signed($urandom) >>> 8);
      sel = $urandom_range(0, 9);
      rq.axis_x = 0;
      rq.axis_y = 0;
      rq.axis_z = 0;
      case (sel)
         0: rq.axis_x = ONE_Q30;
         1: rq.axis_y = -ONE_Q30;
         2: rq.axis_z = ONE_Q30;
         3: begin
            rq.axis_x = 32'sd619925131;   // 1/sqrt(3)
            rq.axis_y = -32'sd619925131;
            rq.axis_z = 32'sd619925131;
         end
         4: begin
            rq.axis_y = 32'sd759250125;   // 1/sqrt(2)
            rq.axis_z = 32'sd759250125;
         end
         5, 6: begin
            rq.axis_x = rand_word();
            rq.axis_y = rand_word();
            rq.axis_z = rand_word();
         end
         default: begin
            rq.axis_x = word_type'($signed($urandom) >>> 2);
            rq.axis_y = word_type'($signed($urandom) >>> 2);
            rq.axis_z = word_type'($signed($urandom) >>> 2);
         end
      endcase
      rq.angle_deg = $urandom_range(0, 2) == 0 ? rand_word() :
                     word_type'($signed($urandom_range(0, 1440 * 65536)) - 720 * 65536);
      return rq;
   endfunction

   // Fill the queue: directed corners first, then random vectors
   initial begin
      req_type rq;
      word_type corner_angles[12] = '{0, 32'sd5898240, 32'sd11796480, 32'sd17694720,
         32'sd23592960, -32'sd5898240, -32'sd11796480, 32'sd5898241, 32'sd5898239,
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd11796481};
      foreach (corner_angles[i]) begin
         rq = '{vec_x: 32'sd65536, vec_y: 32'sd131072, vec_z: -32'sd65536,
                axis_x: 0, axis_y: 0, axis_z: ONE_Q30, angle_deg: corner_angles[i]};
         pending_vectors.push_back(rq);
      end
      // Extreme vector components with unit and non-unit axes to force clipping
      rq = '{vec_x: WORD_MAX, vec_y: WORD_MIN, vec_z: WORD_MAX,
             axis_x: ONE_Q30, axis_y: 0, axis_z: 0, angle_deg: 32'sd2949120};
      pending_vectors.push_back(rq);
      rq = '{vec_x: WORD_MIN, vec_y: WORD_MIN, vec_z: WORD_MIN,
             axis_x: WORD_MAX, axis_y: WORD_MAX, axis_z: WORD_MAX, angle_deg: 32'sd8847360};
      pending_vectors.push_back(rq);
      rq = '{vec_x: WORD_MAX, vec_y: WORD_MAX, vec_z: WORD_MAX,
             axis_x: WORD_MIN, axis_y: WORD_MIN, axis_z: WORD_MIN, angle_deg: -32'sd2949120};
      pending_vectors.push_back(rq);
      rq = '{vec_x: -1, vec_y: 1, vec_z: 0,
             axis_x: -1, axis_y: 1, axis_z: 0, angle_deg: -1};
      pending_vectors.push_back(rq);
      rq = '{vec_x: 32'sd1000000, vec_y: 0, vec_z: 0,
             axis_x: 32'sd619925131, axis_y: 32'sd619925131, axis_z: 32'sd619925131,
             angle_deg: 32'sd7864320};
      pending_vectors.push_back(rq);
      for (int n = 0; n < 1550; n++) begin
         pending_vectors.push_back(random_vector());
         if (n == 700) begin
            // hold off until the pipeline drains
            wait (pending_vectors.size() == 0);
            hold_for_drain = 1;
            wait (expected_rotations.size() == 0);
            hold_for_drain = 0;
         end
      end
      stimulus_done = 1;
   end

   // Driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            expected_rotations.push_back(rotate_vector(req_data));
         end
         if (start && busy) begin
            // hold the current transfer
         end else if (hold_for_drain || pending_vectors.size() == 0) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_data <= pending_vectors.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest expected rotation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rotations.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rotations.pop_front();
            if (rsp_data.rot_x !== want.rot_x)
               $display("%0t: rot_x expected %0d got %0d", $time, want.rot_x, rsp_data.rot_x);
            if (rsp_data.rot_y !== want.rot_y)
               $display("%0t: rot_y expected %0d got %0d", $time, want.rot_y, rsp_data.rot_y);
            if (rsp_data.rot_z !== want.rot_z)
               $display("%0t: rot_z expected %0d got %0d", $time, want.rot_z, rsp_data.rot_z);
            if (rsp_data.saturated !== want.saturated)
               $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                        rsp_data.saturated);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_vectors.size() == 0);
      @(posedge clock);
      wait (!start && expected_rotations.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_rotations.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ----- filelist.f -----
design/aavr_pkg.sv
design/aavr_cordic_cell.sv
design/aavr_matrix.sv
design/axis_angle_vector_rotate_top.sv
dv/axis_angle_vector_rotate_top_tb.sv
